// File: src/rpps_pkg.sv
// ----------------------------------------------------------------------------
// rpps_pkg: shared types, constants and helpers of the prism position solver
// Fixed-point formats, pipeline transaction records and the CORDIC tables.
// ----------------------------------------------------------------------------
package rpps_pkg;

    // Angle width (bits per turn), code width and CORDIC depth.
    localparam int ANGLE_BITS    = 16;
    localparam int CODE_BITS     = 10;
    localparam int CORDIC_STAGES = 16;

    // Lengths carry GUARD fraction bits.
    localparam int GUARD    = 12;
    localparam int ATAN_ENTRIES = 24;
    localparam int STAGES   = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int LEN_W    = 34;
    localparam int S_W      = 17 + GUARD;
    localparam int SQ_BITS  = S_W;
    localparam int REM_W    = SQ_BITS + 2;
    localparam int IDX_W    = 5;

    localparam int IN_UP  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int IN_DN  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int CD_DN  = (ANGLE_BITS > CODE_BITS) ? ANGLE_BITS - CODE_BITS : 0;
    localparam int CD_UP  = (CODE_BITS > ANGLE_BITS) ? CODE_BITS - ANGLE_BITS : 0;
    localparam logic [32:0] CD_RND = (CD_DN > 0) ? (33'd1 << ((CD_DN > 0) ? CD_DN - 1 : 0))
                                                 : 33'd0;

    localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [2:0] REG_A_STRENGTH = 3'd2;
    localparam logic [2:0] REG_B_STRENGTH = 3'd3;
    localparam logic [2:0] REG_A_ZERO     = 3'd4;
    localparam logic [2:0] REG_B_ZERO     = 3'd5;

    typedef enum logic {MODE_ROTATE, MODE_VECTOR} cordic_mode_t;

    // Side data that rides along with a transaction.
    typedef struct packed {
        logic [ANGLE_BITS-1:0] phi;
        logic [S_W-1:0]        r;
        logic                  zero;
        logic                  oor;
    } side_t;

    typedef struct packed {
        logic                  valid;
        logic [LEN_W-1:0]      x;
        logic [LEN_W-1:0]      y;
        logic [ANGLE_BITS-1:0] z;
        side_t                 side;
    } cordic_t;

    typedef struct packed {
        logic                 valid;
        logic [2*SQ_BITS-1:0] rad;
        logic [REM_W-1:0]     rem;
        logic [SQ_BITS-1:0]   root;
        side_t                side;
    } sqrt_t;

    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Arctangent of 2^-i rounded to the angle width.
    function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [IDX_W-1:0] i);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - ANGLE_BITS));
        return sum[32-ANGLE_BITS +: ANGLE_BITS];
    endfunction

    // Remove the CORDIC gain, flooring.
    function automatic logic [LEN_W-1:0] degain(input logic [LEN_W-1:0] v);
        logic signed [LEN_W+31:0] prod;
        prod = $signed(v) * KINV_Q30;
        return prod[LEN_W+29:30];
    endfunction

    // 16-bit turn fraction to the angle width.
    function automatic logic [ANGLE_BITS-1:0] turn16(input logic [15:0] v);
        logic [47:0] t;
        t = ({32'd0, v} << IN_UP) >> IN_DN;
        return t[ANGLE_BITS-1:0];
    endfunction

    // Angle to position code, round half up, wrapping.
    function automatic logic [CODE_BITS-1:0] to_code(input logic [ANGLE_BITS-1:0] a);
        logic [32:0] t;
        t = ((33'(a) + CD_RND) >> CD_DN) << CD_UP;
        return t[CODE_BITS-1:0];
    endfunction

endpackage

// File: src/rpps_cordic_cell.sv
// ----------------------------------------------------------------------------
// rpps_cordic_cell: one CORDIC micro-rotation
// Rotation or vectoring step with a registered output and side data.
// ----------------------------------------------------------------------------
module rpps_cordic_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  rpps_pkg::cordic_mode_t  mode,
    input  logic [rpps_pkg::IDX_W-1:0] idx,
    input  rpps_pkg::cordic_t       cin,
    output rpps_pkg::cordic_t       cout
);
    import rpps_pkg::*;

    cordic_t cout_reg;
    cordic_t cout_next;
    logic signed [LEN_W-1:0] xs;
    logic signed [LEN_W-1:0] ys;
    logic signed [LEN_W-1:0] dx;
    logic signed [LEN_W-1:0] dy;
    logic [ANGLE_BITS-1:0]   step;
    logic                    ccw;

    // Direction decision and shift-add step.
    always_comb
    begin
        xs   = $signed(cin.x);
        ys   = $signed(cin.y);
        dx   = xs >>> idx;
        dy   = ys >>> idx;
        step = atan_step(idx);
        if (mode == MODE_ROTATE)
        begin
            ccw = ~cin.z[ANGLE_BITS-1];
        end
        else
        begin
            ccw = ys[LEN_W-1];
        end
        cout_next = cin;
        if (ccw)
        begin
            cout_next.x = xs - dy;
            cout_next.y = ys + dx;
            cout_next.z = cin.z - step;
        end
        else
        begin
            cout_next.x = xs + dy;
            cout_next.y = ys - dx;
            cout_next.z = cin.z + step;
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cout_reg <= cout_next;
        end
    end

    assign cout = cout_reg;

endmodule

// File: src/rpps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rpps_sqrt_cell: one digit of an integer square root
// Brings down two radicand bits and decides one root bit per cell.
// ----------------------------------------------------------------------------
module rpps_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  rpps_pkg::sqrt_t sin,
    output rpps_pkg::sqrt_t sout
);
    import rpps_pkg::*;

    sqrt_t sout_reg;
    sqrt_t sout_next;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;

    // Trial subtraction of (4 * root + 1).
    always_comb
    begin
        cur   = {sin.rem, sin.rad[2*SQ_BITS-1 -: 2]};
        trial = {2'b00, sin.root, 2'b01};
        sout_next     = sin;
        sout_next.rad = {sin.rad[2*SQ_BITS-3:0], 2'b00};
        if (cur >= trial)
        begin
            sout_next.rem  = REM_W'(cur - trial);
            sout_next.root = {sin.root[SQ_BITS-2:0], 1'b1};
        end
        else
        begin
            sout_next.rem  = REM_W'(cur);
            sout_next.root = {sin.root[SQ_BITS-2:0], 1'b0};
        end
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sout_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            sout_reg <= sout_next;
        end
    end

    assign sout = sout_reg;

endmodule

// File: src/risley_prism_position_solver_top.sv
// ----------------------------------------------------------------------------
// risley_prism_position_solver_top: Risley prism pair inverse steering
// Wanted dispersion to two prism position codes, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid in_ready target_angle            | in
//          | target_modulus                            |
//  output  | out_valid out_ready prism_a_code          | out
//          | prism_b_code out_of_reach                 |
//  config  | cfg_valid cfg_ready cfg_index cfg_data    | in
//
//  One transaction is taken every cycle while the output is not stalled; it
//  passes through the chain of CORDIC and square-root cells.
//  Reset clears the stage valid bits and loads the register defaults.
//  A stalled output freezes the whole chain; in_ready follows the output side.
//  Configuration writes are always accepted.
module risley_prism_position_solver_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [15:0]                    target_angle,
    input  logic [15:0]                    target_modulus,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rpps_pkg::CODE_BITS-1:0] prism_a_code,
    output logic [rpps_pkg::CODE_BITS-1:0] prism_b_code,
    output logic                           out_of_reach,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    import rpps_pkg::*;

    logic advance;

    logic [15:0] offset_x_reg;
    logic [15:0] offset_y_reg;
    logic [15:0] a_strength_reg;
    logic [15:0] b_strength_reg;
    logic [15:0] a_zero_reg;
    logic [15:0] b_zero_reg;

    cordic_t rot_pipe  [STAGES+1];
    cordic_t vec_pipe  [STAGES+1];
    cordic_t vec2_pipe [STAGES+1];
    sqrt_t   sq_pipe   [SQ_BITS+1];

    cordic_t pre_rot_reg;
    cordic_t pre_rot_next;
    cordic_t dg_reg;
    cordic_t off_reg;
    cordic_t vpre_reg;
    cordic_t mag_reg;
    cordic_t cmp_reg;
    logic                 prod_valid_reg;
    logic [2*S_W-1:0]     ss_reg;
    logic [2*S_W-1:0]     rr_reg;
    side_t                prod_side_reg;
    sqrt_t                diff_reg;
    cordic_t              v2pre_reg;

    logic                  out_valid_reg;
    logic [CODE_BITS-1:0]  a_code_reg;
    logic [CODE_BITS-1:0]  b_code_reg;
    logic                  oor_reg;

    logic [S_W-1:0]        s_now;
    logic [ANGLE_BITS-1:0] theta;
    logic [ANGLE_BITS:0]   qsum;
    logic [1:0]            quad;
    logic [LEN_W-1:0]      m_len;
    logic [LEN_W-1:0]      off_x_len;
    logic [LEN_W-1:0]      off_y_len;
    logic [LEN_W-1:0]      sub_x;
    logic [LEN_W-1:0]      sub_y;
    logic [ANGLE_BITS-1:0] ang_a;
    logic [ANGLE_BITS-1:0] ang_b;

    // The chain moves whenever the output register can take a result.
    assign advance  = ~out_valid_reg | out_ready;
    assign in_ready = advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg   <= 16'd0;
            offset_y_reg   <= 16'd0;
            a_strength_reg <= 16'd16;
            b_strength_reg <= 16'd16;
            a_zero_reg     <= 16'd0;
            b_zero_reg     <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OFFSET_X:   offset_x_reg   <= cfg_data;
                REG_OFFSET_Y:   offset_y_reg   <= cfg_data;
                REG_A_STRENGTH: a_strength_reg <= cfg_data;
                REG_B_STRENGTH: b_strength_reg <= cfg_data;
                REG_A_ZERO:     a_zero_reg     <= cfg_data;
                REG_B_ZERO:     b_zero_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Strength sum in the length format.
    assign s_now = {17'(a_strength_reg) + 17'(b_strength_reg), {GUARD{1'b0}}};

    // Quarter-turn prerotation of (modulus, 0).
    always_comb
    begin
        theta = turn16(target_angle);
        qsum  = {1'b0, theta} + {1'b0, QUARTER >> 1};
        quad  = qsum[ANGLE_BITS-1 -: 2];
        m_len = {{(LEN_W-16-GUARD){1'b0}}, target_modulus, {GUARD{1'b0}}};
        pre_rot_next       = '0;
        pre_rot_next.valid = in_valid;
        pre_rot_next.z     = theta - ANGLE_BITS'(quad) * QUARTER;
        case (quad)
            2'd0:    pre_rot_next.x = m_len;
            2'd1:    pre_rot_next.y = m_len;
            2'd2:    pre_rot_next.x = LEN_W'(-$signed(m_len));
            default: pre_rot_next.y = LEN_W'(-$signed(m_len));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_rot_reg.valid <= 1'b0;
        end
        else if (advance)
        begin
            pre_rot_reg <= pre_rot_next;
        end
    end

    assign rot_pipe[0] = pre_rot_reg;

    // Rotation cells, vectoring cells and the acos vectoring cells.
    for (genvar i = 0; i < STAGES; i++)
    begin : g_cordic
        rpps_cordic_cell u_rot (
            .clk (clk), .rst_n (rst_n), .en (advance), .mode (MODE_ROTATE),
            .idx (IDX_W'(i)), .cin (rot_pipe[i]), .cout (rot_pipe[i+1])
        );
        rpps_cordic_cell u_vec (
            .clk (clk), .rst_n (rst_n), .en (advance), .mode (MODE_VECTOR),
            .idx (IDX_W'(i)), .cin (vec_pipe[i]), .cout (vec_pipe[i+1])
        );
        rpps_cordic_cell u_vec2 (
            .clk (clk), .rst_n (rst_n), .en (advance), .mode (MODE_VECTOR),
            .idx (IDX_W'(i)), .cin (vec2_pipe[i]), .cout (vec2_pipe[i+1])
        );
    end

    for (genvar k = 0; k < SQ_BITS; k++)
    begin : g_sqrt
        rpps_sqrt_cell u_sq (
            .clk (clk), .rst_n (rst_n), .en (advance),
            .sin (sq_pipe[k]), .sout (sq_pipe[k+1])
        );
    end

    assign sq_pipe[0]   = diff_reg;
    assign vec_pipe[0]  = vpre_reg;
    assign vec2_pipe[0] = v2pre_reg;

    // Offset subtraction operands.
    assign off_x_len = LEN_W'($signed({offset_x_reg, {GUARD{1'b0}}}));
    assign off_y_len = LEN_W'($signed({offset_y_reg, {GUARD{1'b0}}}));
    assign sub_x     = dg_reg.x - off_x_len;
    assign sub_y     = dg_reg.y - off_y_len;

    // Final prism angles.
    assign ang_a = vec2_pipe[STAGES].side.phi - vec2_pipe[STAGES].z + turn16(a_zero_reg);
    assign ang_b = vec2_pipe[STAGES].side.phi + vec2_pipe[STAGES].z + turn16(b_zero_reg);

    // Glue stages between the cell rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dg_reg.valid   <= 1'b0;
            off_reg.valid  <= 1'b0;
            vpre_reg.valid <= 1'b0;
            mag_reg.valid  <= 1'b0;
            cmp_reg.valid  <= 1'b0;
            prod_valid_reg <= 1'b0;
            diff_reg.valid <= 1'b0;
            v2pre_reg.valid <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            // Gain removal after rotation.
            dg_reg   <= rot_pipe[STAGES];
            dg_reg.x <= degain(rot_pipe[STAGES].x);
            dg_reg.y <= degain(rot_pipe[STAGES].y);

            // Camera offset and zero-vector flag.
            off_reg           <= dg_reg;
            off_reg.x         <= sub_x;
            off_reg.y         <= sub_y;
            off_reg.side.zero <= (sub_x == '0) && (sub_y == '0);

            // Left half plane is folded over by half a turn.
            vpre_reg <= off_reg;
            if (off_reg.x[LEN_W-1])
            begin
                vpre_reg.x <= LEN_W'(-$signed(off_reg.x));
                vpre_reg.y <= LEN_W'(-$signed(off_reg.y));
                vpre_reg.z <= HALF;
            end
            else
            begin
                vpre_reg.z <= '0;
            end

            // Length and direction of the corrected vector.
            mag_reg          <= vec_pipe[STAGES];
            mag_reg.x        <= degain(vec_pipe[STAGES].x);
            mag_reg.side.phi <= vec_pipe[STAGES].side.zero ? '0 : vec_pipe[STAGES].z;

            // Reach check.
            cmp_reg        <= mag_reg;
            cmp_reg.side.r <= mag_reg.x[S_W-1:0];
            cmp_reg.side.oor <= (s_now == '0) ||
                                ($signed(mag_reg.x) > $signed(LEN_W'(s_now)));

            // Squares of strength sum and length.
            prod_valid_reg <= cmp_reg.valid;
            prod_side_reg  <= cmp_reg.side;
            ss_reg         <= s_now * s_now;
            rr_reg         <= cmp_reg.side.r * cmp_reg.side.r;

            // Radicand for the square-root row.
            diff_reg.valid <= prod_valid_reg;
            diff_reg.rad   <= ss_reg - rr_reg;
            diff_reg.rem   <= '0;
            diff_reg.root  <= '0;
            diff_reg.side  <= prod_side_reg;

            // Half cross angle is the direction of (r, root).
            v2pre_reg.valid <= sq_pipe[SQ_BITS].valid;
            v2pre_reg.x     <= LEN_W'(sq_pipe[SQ_BITS].side.r);
            v2pre_reg.y     <= LEN_W'(sq_pipe[SQ_BITS].root);
            v2pre_reg.z     <= '0;
            v2pre_reg.side  <= sq_pipe[SQ_BITS].side;

            // Output register.
            out_valid_reg <= vec2_pipe[STAGES].valid;
            oor_reg       <= vec2_pipe[STAGES].side.oor;
            a_code_reg    <= vec2_pipe[STAGES].side.oor ? '0 : to_code(ang_a);
            b_code_reg    <= vec2_pipe[STAGES].side.oor ? '0 : to_code(ang_b);
        end
    end

    assign out_valid    = out_valid_reg;
    assign prism_a_code = a_code_reg;
    assign prism_b_code = b_code_reg;
    assign out_of_reach = oor_reg;

`ifndef SYNTH
    // An out-of-reach result carries zero codes.
    a_oor_codes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_reach |-> (prism_a_code == '0) && (prism_b_code == '0))
        else $error("out-of-reach result with nonzero codes");

    // An accepted transaction enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> rot_pipe[0].valid)
        else $error("accepted transaction lost at entry");

    // A stall freezes the last cell row.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vec2_pipe[STAGES].valid))
        else $error("chain moved during a stall");
`endif

endmodule

// File: tb/sv/rpps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpps_checker: prism position predictor and result scoreboard
// Watches the command, result and register channels of the solver. Each
// accepted command is solved here in fixed point: polar to x,y, offset
// removal, CORDIC vectoring, reach check, arccos and code rounding. Results
// are compared field by field with the oldest pending solution, in order.
// ----------------------------------------------------------------------------
module rpps_checker
    import rpps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [15:0]          target_angle,
    input  logic [15:0]          target_modulus,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CODE_BITS-1:0] prism_a_code,
    input  logic [CODE_BITS-1:0] prism_b_code,
    input  logic                 out_of_reach,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output int                   errors,
    output int                   pending
);

    typedef struct {
        logic [9:0] code_a;
        logic [9:0] code_b;
        logic       oor;
    } pointing_t;

    // Arctangent of 2^-i as a fraction of a turn, 32-bit scale.
    localparam logic [31:0] ARCTAN_TURNS [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D
    };
    localparam longint GAIN_INV_Q30 = 64'sd652032874;

    logic signed [15:0] off_x, off_y;
    logic [15:0]        str_a, str_b, zero_a, zero_b;
    pointing_t          solutions[$];

    assign pending = solutions.size();

    function automatic logic [15:0] arctan_step(input int i);
        logic [31:0] sum;
        sum = ARCTAN_TURNS[i] + 32'h0000_8000;
        return sum[31:16];
    endfunction

    function automatic longint remove_gain(input longint v);
        return (v * GAIN_INV_Q30) >>> 30;
    endfunction

    // Turn (m, 0) by the angle, starting with the nearest quarter turn.
    function automatic void polar_to_xy(input longint m, input logic [15:0] ang,
                                        output longint xo, output longint yo);
        logic [16:0] biased;
        logic [1:0]  quad;
        logic [15:0] z;
        longint      x, y, t;
        biased = {1'b0, ang} + 17'd8192;
        quad   = biased[15:14];
        z      = ang - {quad, 14'd0};
        x = 0;
        y = 0;
        case (quad)
            2'd0: x = m;
            2'd1: y = m;
            2'd2: x = -m;
            default: y = -m;
        endcase
        for (int i = 0; i < 16; i++)
        begin
            if (!z[15])
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arctan_step(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arctan_step(i);
            end
            x = t;
        end
        xo = remove_gain(x);
        yo = remove_gain(y);
    endfunction

    // Direction and length of (x, y); left half plane is folded first.
    function automatic void xy_to_polar(input longint xi, input longint yi,
                                        output logic [15:0] ang, output longint len);
        longint      x, y, t;
        logic [15:0] z;
        x = xi;
        y = yi;
        z = 16'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 16'h8000;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + arctan_step(i);
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - arctan_step(i);
            end
            x = t;
        end
        ang = z;
        len = remove_gain(x);
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned root, trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return longint'(root);
    endfunction

    function automatic logic [9:0] angle_to_code(input logic [15:0] a);
        logic [16:0] t;
        t = {1'b0, a} + 17'd32;
        return t[15:6];
    endfunction

    function automatic pointing_t solve_pointing(input logic [15:0] ang,
                                                 input logic [15:0] modulus);
        pointing_t   res;
        longint      x, y, r, s, q, unused_len;
        logic [15:0] phi, half_cross;
        polar_to_xy(longint'(modulus) <<< 12, ang, x, y);
        x = x - (longint'(off_x) <<< 12);
        y = y - (longint'(off_y) <<< 12);
        xy_to_polar(x, y, phi, r);
        if (x == 0 && y == 0)
            phi = 16'd0;
        s = (longint'(str_a) + longint'(str_b)) <<< 12;
        if (s == 0 || r > s)
        begin
            res.code_a = '0;
            res.code_b = '0;
            res.oor    = 1'b1;
            return res;
        end
        q = floor_sqrt(longint'(s * s - r * r));
        xy_to_polar(r, q, half_cross, unused_len);
        res.code_a = angle_to_code(phi - half_cross + zero_a);
        res.code_b = angle_to_code(phi + half_cross + zero_b);
        res.oor    = 1'b0;
        return res;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    // Register shadow, loaded with the reset defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x  <= '0;
            off_y  <= '0;
            str_a  <= 16'd16;
            str_b  <= 16'd16;
            zero_a <= '0;
            zero_b <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OFFSET_X:   off_x  <= cfg_data;
                REG_OFFSET_Y:   off_y  <= cfg_data;
                REG_A_STRENGTH: str_a  <= cfg_data;
                REG_B_STRENGTH: str_b  <= cfg_data;
                REG_A_ZERO:     zero_a <= cfg_data;
                REG_B_ZERO:     zero_b <= cfg_data;
                default: ;
            endcase
        end
    end

    // Solve each accepted command and check each accepted result.
    always @(posedge clk)
    begin
        pointing_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                solutions.push_back(solve_pointing(target_angle, target_modulus));
            if (out_valid && out_ready)
            begin
                if (solutions.size() == 0)
                    report("unexpected result transaction", 1, 0);
                else
                begin
                    want = solutions.pop_front();
                    if (prism_a_code !== want.code_a)
                        report("prism_a_code", prism_a_code, want.code_a);
                    if (prism_b_code !== want.code_b)
                        report("prism_b_code", prism_b_code, want.code_b);
                    if (out_of_reach !== want.oor)
                        report("out_of_reach", out_of_reach, want.oor);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the prism position solver
// Drives directed corner commands and randomized register settings with
// commands shaped around the prism reach, under bursty input and stalling
// output, including one long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import rpps_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int WATCHDOG_MAX = 3000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [15:0]          target_angle = '0;
    logic [15:0]          target_modulus = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CODE_BITS-1:0] prism_a_code;
    logic [CODE_BITS-1:0] prism_b_code;
    logic                 out_of_reach;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    int                   errors;
    int                   pending;

    int                   burst_left = 0;
    int                   strength_sum = 32;
    int                   idle_cycles = 0;

    risley_prism_position_solver_top i_dut (.*);

    rpps_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: stall pattern picked at random from three modes; one long hold.
    always @(posedge clk)
    begin
        static int cyc = 0;
        static int mode = 0;
        static int hold = 0;
        static bit held = 1'b0;
        cyc++;
        if (cyc % 256 == 0)
            mode = $urandom_range(0, 2);
        if (!held && in_valid && cyc > 2000)
        begin
            held = 1'b1;
            hold = 400;
        end
        if (hold > 0)
        begin
            hold--;
            out_ready <= 1'b0;
        end
        else if (mode == 0)
            out_ready <= 1'b1;
        else if (mode == 1)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("** risley_prism_position_solver_top: FAILED **");
            $finish;
        end
    end

    task automatic send_command(input logic [15:0] ang, input logic [15:0] modulus);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        target_angle   <= ang;
        target_modulus <= modulus;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // Let every pending result out, then let the pipeline empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; cfg_valid is dropped again afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [15:0] sa, input logic [15:0] sb,
                                  input logic [15:0] za, input logic [15:0] zb);
        wait_idle();
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_A_STRENGTH, sa);
        write_reg(REG_B_STRENGTH, sb);
        write_reg(REG_A_ZERO, za);
        write_reg(REG_B_ZERO, zb);
        strength_sum = int'(sa) + int'(sb);
    endtask

    function automatic logic [15:0] pick_strength();
        case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // Mostly within reach, some right at the edge, some anywhere.
    function automatic logic [15:0] pick_modulus();
        int top, pick;
        top = strength_sum + strength_sum / 8;
        if (top > 65535)
            top = 65535;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return 16'($urandom_range(0, top));
        if (pick == 8)
            return 16'($urandom_range(strength_sum > 2 ? strength_sum - 2 : 0,
                                      strength_sum + 2 > 65535 ? 65535 : strength_sum + 2));
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] pick_offset(input bool_extreme);
        int span;
        if (bool_extreme)
            return 16'($urandom());
        span = strength_sum / 8 + 1;
        if (span > 32767)
            span = 32767;
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    initial
    begin
        logic [15:0] sa, sb;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: zero vector, exact reach, just beyond, extremes.
        send_command(16'h0000, 16'd0);
        send_command(16'hFFFF, 16'd32);
        send_command(16'h8000, 16'd33);
        send_command(16'h4000, 16'd31);
        send_command(16'hC000, 16'hFFFF);
        send_command(16'h2000, 16'd1);
        send_command(16'h6000, 16'd16);
        send_command(16'hFFFF, 16'd0);
        send_command(16'h0001, 16'd20);

        // Register extremes.
        apply_settings(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000);
        send_command(16'h0000, 16'hFFFF);
        send_command(16'hFFFF, 16'h0000);
        send_command(16'h8000, 16'h8000);
        send_command(16'h6000, 16'hFFFF);
        send_command(16'hA000, 16'h1234);

        // Zero strength sum; writes to unused indexes must be ignored.
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h2000);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h5555);
        send_command(16'h0000, 16'd0);
        send_command(16'h3000, 16'd100);
        send_command(16'hFFFF, 16'hFFFF);

        // Minimum strengths with opposite offset extremes.
        apply_settings(16'h7FFF, 16'h8000, 16'd1, 16'd1, 16'h0000, 16'hFFFF);
        send_command(16'h1000, 16'd0);
        send_command(16'h9000, 16'hFFFF);

        // Randomized settings, commands shaped around the reach.
        for (int p = 0; p < 8; p++)
        begin
            sa = pick_strength();
            sb = pick_strength();
            strength_sum = int'(sa) + int'(sb);
            apply_settings(pick_offset(p == 3), pick_offset(p == 3), sa, sb,
                           16'($urandom()), 16'($urandom()));
            for (int n = 0; n < 85; n++)
                send_command(16'($urandom()), pick_modulus());
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("** risley_prism_position_solver_top: PASSED **");
        else
            $display("** risley_prism_position_solver_top: FAILED **");
        $finish;
    end

endmodule
